### rtl/alc_pkg.sv
// Shared types and constants for the array list with cursor.
// Used by the controller, the datapath and the top level.
package alc_pkg;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_FIRST  = 3'd1;
    localparam logic [2:0] OP_NEXT   = 3'd2;
    localparam logic [2:0] OP_REMOVE = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    typedef struct packed {
        logic insert;
        logic clear;
        logic reject;
        logic first;
        logic next;
        logic rem_read;
        logic capture;
        logic shift_start;
        logic shift_step;
        logic rem_finish;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic next_ok;
        logic remove_ok;
        logic shift_more;
        logic shift_last;
    } status_t;

endpackage

### rtl/array_list_with_cursor.sv
// Bounded array list with cursor. One request at a time; insert, clear and
// rejected requests go straight to the done state, first and next pass through
// a fetch state (one registered RAM read). Remove reads the cursor entry, then
// moves each later entry down one place through the single RAM write port.
// The next request is accepted the cycle after the result is loaded.
// Reset clears the count and the cursor; RAM contents stay undefined, no sweep.
module array_list_with_cursor #(
    parameter int LIST_DEPTH = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [2:0]                       opcode,
    input  logic signed [31:0]               item_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             ok,
    output logic signed [31:0]               read_data,
    output logic [$clog2(LIST_DEPTH+1)-1:0]  entry_count
);

    alc_pkg::cmd_t    cmd;
    alc_pkg::status_t status;

    alc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    alc_dp #(
        .LIST_DEPTH (LIST_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_data   (item_data),
        .cmd         (cmd),
        .status      (status),
        .ok          (ok),
        .read_data   (read_data),
        .entry_count (entry_count)
    );

endmodule

### rtl/alc_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module alc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/alc_ctrl.sv
// Request sequencer for the array list: handshakes and command issue.
// Depends on alc_pkg (cmd_t, status_t, opcodes).
module alc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [2:0]       opcode,
    output logic             out_valid,
    input  logic             out_stall,
    input  alc_pkg::status_t status,
    output alc_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_REM_FETCH,
        S_SHIFT,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DONE;
                    unique case (opcode)
                        alc_pkg::OP_INSERT:
                        begin
                            if (status.full)
                                cmd.reject = 1'b1;
                            else
                                cmd.insert = 1'b1;
                        end
                        alc_pkg::OP_FIRST:
                        begin
                            if (status.empty)
                                cmd.reject = 1'b1;
                            else
                            begin
                                cmd.first  = 1'b1;
                                state_next = S_FETCH;
                            end
                        end
                        alc_pkg::OP_NEXT:
                        begin
                            if (status.next_ok)
                            begin
                                cmd.next   = 1'b1;
                                state_next = S_FETCH;
                            end
                            else
                                cmd.reject = 1'b1;
                        end
                        alc_pkg::OP_REMOVE:
                        begin
                            if (status.remove_ok)
                            begin
                                cmd.rem_read = 1'b1;
                                state_next   = S_REM_FETCH;
                            end
                            else
                                cmd.reject = 1'b1;
                        end
                        alc_pkg::OP_CLEAR:
                        begin
                            cmd.clear = 1'b1;
                        end
                        default:
                        begin
                            cmd.reject = 1'b1;
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                cmd.capture = 1'b1;
                state_next  = S_DONE;
            end
            S_REM_FETCH:
            begin
                cmd.capture = 1'b1;
                if (status.shift_more)
                begin
                    cmd.shift_start = 1'b1;
                    state_next      = S_SHIFT;
                end
                else
                begin
                    cmd.rem_finish = 1'b1;
                    state_next     = S_DONE;
                end
            end
            S_SHIFT:
            begin
                cmd.shift_step = 1'b1;
                if (status.shift_last)
                begin
                    cmd.rem_finish = 1'b1;
                    state_next     = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/alc_dp.sv
// Datapath for the array list: entry RAM, count, cursor, shift pointer, result.
// Depends on alc_pkg (cmd_t, status_t) and alc_ram.
module alc_dp #(
    parameter int LIST_DEPTH = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic signed [31:0]                item_data,
    input  alc_pkg::cmd_t                     cmd,
    output alc_pkg::status_t                  status,
    output logic                              ok,
    output logic signed [31:0]                read_data,
    output logic [$clog2(LIST_DEPTH+1)-1:0]   entry_count
);

    localparam int IDX_W = $clog2(LIST_DEPTH);
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam logic [IDX_W-1:0] ONE_IDX = IDX_W'(1);
    localparam logic [IDX_W-1:0] TWO_IDX = IDX_W'(2);
    localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);
    localparam logic [CNT_W-1:0] TWO_CNT = CNT_W'(2);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(LIST_DEPTH);

    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  cur_valid_reg, cur_valid_next;
    logic [IDX_W-1:0]      cur_reg, cur_next;
    logic [IDX_W-1:0]      wptr_reg, wptr_next;
    logic                  res_ok_reg, res_ok_next;
    logic [31:0]           res_data_reg, res_data_next;
    logic                  out_ok_reg;
    logic [31:0]           out_data_reg;
    logic [CNT_W-1:0]      out_count_reg;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [IDX_W-1:0]      ram_raddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [DATA_WIDTH-1:0] ram_q;
    logic [IDX_W-1:0]      next_idx;
    logic [CNT_W-1:0]      cur_wide;
    logic [31:0]           rd_word;

    alc_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (LIST_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    assign cur_wide = CNT_W'(cur_reg);
    assign next_idx = cur_valid_reg ? (cur_reg + ONE_IDX) : '0;
    assign rd_word  = 32'(ram_q);

    assign status.full       = (count_reg == FULL_CNT);
    assign status.empty      = (count_reg == '0);
    assign status.next_ok    = cur_valid_reg ? ((cur_wide + ONE_CNT) < count_reg)
                                             : (count_reg != '0);
    assign status.remove_ok  = cur_valid_reg && (cur_wide < count_reg);
    assign status.shift_more = (cur_wide + ONE_CNT) < count_reg;
    assign status.shift_last = (CNT_W'(wptr_reg) + TWO_CNT) == count_reg;

    assign ram_we    = cmd.insert || cmd.shift_step;
    assign ram_waddr = cmd.insert ? count_reg[IDX_W-1:0] : wptr_reg;
    assign ram_wdata = cmd.insert ? DATA_WIDTH'($unsigned(item_data)) : ram_q;

    always_comb
    begin
        ram_raddr = cur_reg;
        if (cmd.first)
            ram_raddr = '0;
        else if (cmd.next)
            ram_raddr = next_idx;
        else if (cmd.rem_read)
            ram_raddr = cur_reg;
        else if (cmd.shift_start)
            ram_raddr = cur_reg + ONE_IDX;
        else if (cmd.shift_step)
            ram_raddr = wptr_reg + TWO_IDX;
    end

    always_comb
    begin
        count_next     = count_reg;
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        wptr_next      = wptr_reg;
        res_ok_next    = res_ok_reg;
        res_data_next  = res_data_reg;

        if (cmd.insert)
        begin
            count_next    = count_reg + ONE_CNT;
            res_ok_next   = 1'b1;
            res_data_next = '0;
        end
        if (cmd.clear)
        begin
            count_next     = '0;
            cur_valid_next = 1'b0;
            res_ok_next    = 1'b1;
            res_data_next  = '0;
        end
        if (cmd.reject)
        begin
            res_ok_next   = 1'b0;
            res_data_next = '0;
        end
        if (cmd.first)
        begin
            cur_valid_next = 1'b1;
            cur_next       = '0;
        end
        if (cmd.next)
        begin
            cur_valid_next = 1'b1;
            cur_next       = next_idx;
        end
        if (cmd.capture)
        begin
            res_ok_next   = 1'b1;
            res_data_next = rd_word;
        end
        if (cmd.shift_start)
            wptr_next = cur_reg;
        if (cmd.shift_step)
            wptr_next = wptr_reg + ONE_IDX;
        if (cmd.rem_finish)
        begin
            count_next     = count_reg - ONE_CNT;
            cur_valid_next = (cur_reg != '0);
            cur_next       = cur_reg - ONE_IDX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cur_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            cur_valid_reg <= cur_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        wptr_reg     <= wptr_next;
        res_ok_reg   <= res_ok_next;
        res_data_reg <= res_data_next;
        if (cmd.load_out)
        begin
            out_ok_reg    <= res_ok_reg;
            out_data_reg  <= res_data_reg;
            out_count_reg <= count_reg;
        end
    end

    assign ok          = out_ok_reg;
    assign read_data   = out_data_reg;
    assign entry_count = out_count_reg;

endmodule

### rtl/alc_checker.sv
// Port-level checks for array_list_with_cursor, attached by bind.
// No package dependencies.
module alc_checker #(
    parameter int LIST_DEPTH = 64
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic                             ok,
    input logic signed [31:0]               read_data,
    input logic [$clog2(LIST_DEPTH+1)-1:0]  entry_count
);

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(ok) && $stable(read_data)
                                   && $stable(entry_count))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while previous one in progress");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> read_data == 32'sd0)
        else $error("rejected request returned data");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> entry_count <= CNT_W'(LIST_DEPTH))
        else $error("entry count beyond depth");

endmodule

bind array_list_with_cursor alc_checker #(
    .LIST_DEPTH (LIST_DEPTH)
) u_alc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .ok          (ok),
    .read_data   (read_data),
    .entry_count (entry_count)
);
